// ===== design/bitmap_page_allocator_core_assert.svh =====
// Assertion macros for the bitmap page allocator.
// No dependencies; included by files that carry concurrent checks.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`define BPA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BPA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== design/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
// No dependencies.
package bpa_pkg;

  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = 2048;
  localparam int WADDR_W    = 11;
  localparam int BOFF_W     = 5;
  localparam int PAGE_W     = 16;
  localparam int LEN_W      = 9;
  localparam int CNT_W      = 17;
  localparam logic [LEN_W-1:0] MAX_RUN = 9'd256;
  localparam logic [CNT_W-1:0] TOTAL_RESET = 17'd65536;

  typedef enum logic [2:0] {
    OP_ALLOC     = 3'd0,
    OP_FREE      = 3'd1,
    OP_TEST      = 3'd2,
    OP_MARK_USED = 3'd3,
    OP_MARK_FREE = 3'd4
  } opcode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TEST_RD,
    ST_TEST_CHK,
    ST_SCAN_RD,
    ST_SCAN_BITS,
    ST_RUN_RD,
    ST_RUN_WR,
    ST_FIN
  } state_t;

endpackage

// ===== design/bitmap_page_allocator_core.sv =====
// First-fit bitmap page allocator, top level.
// Depends on bpa_pkg and bitmap_page_allocator_core_assert.svh.
//
// One bit per page (1 = used) lives in a 2048 x 32 single-port RAM with a
// registered read. After reset the RAM is swept to zero, one word a cycle;
// in_ready stays low meanwhile (cfg writes still land). Items are handled
// one at a time. Test reads the word, then picks out the bit. Free, mark
// used and mark free read and then write back each bitmap word the run
// touches. Allocate scans words from page 1 upwards: a read per word, then
// four steps of eight pages each, then the write-back of the run as for
// mark used. The scan and the read-modify-write share the one RAM port. A
// finished result sits in the output register, so the next item is taken
// while it waits for out_ready.
`include "bitmap_page_allocator_core_assert.svh"

module bitmap_page_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_page_index,
  input  logic [8:0]  in_run_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_success,
  output logic [15:0] out_start_page,
  output logic        out_page_used,
  output logic [16:0] out_used_count
);

  bpa_pkg::state_t state_r, state_nxt;

  // bitmap RAM
  logic [bpa_pkg::WORD_BITS-1:0] mem [bpa_pkg::NUM_WORDS];
  logic                          mem_we, mem_re;
  logic [bpa_pkg::WADDR_W-1:0]   mem_addr;
  logic [bpa_pkg::WORD_BITS-1:0] mem_wdata, rd_data_r;

  logic [bpa_pkg::WADDR_W-1:0] clr_cnt_r;
  logic [bpa_pkg::CNT_W-1:0]   total_r, used_r;
  logic [bpa_pkg::PAGE_W-1:0]  page_r, lo_r, hi_r, start_r;
  logic [bpa_pkg::LEN_W-1:0]   len_r, run_r;
  logic [bpa_pkg::WADDR_W-1:0] word_r;
  logic [1:0]                  sub_r;
  logic                        set_r, success_r, tested_r;
  logic                        out_valid_r;
  logic                        out_load;

  // accept-side decode
  logic                        accept;
  logic [bpa_pkg::LEN_W-1:0]   len_c;
  logic                        alloc_go, run_go;
  logic [bpa_pkg::CNT_W:0]     need_c;

  assign in_ready = (state_r == bpa_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign len_c    = (in_run_length > bpa_pkg::MAX_RUN) ? bpa_pkg::MAX_RUN : in_run_length;
  assign need_c   = {1'b0, used_r} + {{(bpa_pkg::CNT_W + 1 - bpa_pkg::LEN_W){1'b0}}, len_c};
  assign alloc_go = (len_c != '0) && (need_c <= {1'b0, total_r});
  assign run_go   = (in_page_index != '0) && (len_c != '0);

  // load the output register once the previous result has gone
  assign out_load = (state_r == bpa_pkg::ST_FIN) && (!out_valid_r || out_ready);

  // scan eight pages of the current word per cycle
  logic [7:0]                chunk;
  logic                      found;
  logic [2:0]                found_k;
  logic [bpa_pkg::LEN_W-1:0] run_c;
  logic [bpa_pkg::PAGE_W-1:0] found_pg, found_start;

  always_comb begin
    chunk   = rd_data_r[{sub_r, 3'b000} +: 8];
    run_c   = run_r;
    found   = 1'b0;
    found_k = '0;
    for (int k = 0; k < 8; k++) begin
      if (!found) begin
        if (chunk[k] || (word_r == '0 && sub_r == '0 && k == 0)) begin
          run_c = '0;
        end else begin
          run_c = run_c + 1'b1;
          if (run_c == len_r) begin
            found   = 1'b1;
            found_k = 3'(k);
          end
        end
      end
    end
    found_pg    = {word_r, sub_r, found_k};
    found_start = found_pg + 16'd1 - {{(bpa_pkg::PAGE_W - bpa_pkg::LEN_W){1'b0}}, len_r};
  end

  // last page of a run given on the input, clipped to the top of the map
  logic [bpa_pkg::PAGE_W:0]  in_hi_c;
  logic [bpa_pkg::PAGE_W-1:0] in_hi_clip;
  assign in_hi_c    = {1'b0, in_page_index} + {8'd0, len_c} - 17'd1;
  assign in_hi_clip = in_hi_c[bpa_pkg::PAGE_W] ? '1 : in_hi_c[bpa_pkg::PAGE_W-1:0];

  // mask of the run within the current word
  logic [bpa_pkg::BOFF_W-1:0]    lo_bit, hi_bit;
  logic [bpa_pkg::WORD_BITS-1:0] run_mask;
  logic                          last_word;
  always_comb begin
    lo_bit    = (word_r == lo_r[15:5]) ? lo_r[4:0] : '0;
    hi_bit    = (word_r == hi_r[15:5]) ? hi_r[4:0] : '1;
    run_mask  = ({bpa_pkg::WORD_BITS{1'b1}} << lo_bit) &
                ({bpa_pkg::WORD_BITS{1'b1}} >> (5'd31 - hi_bit));
    last_word = (word_r == hi_r[15:5]);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpa_pkg::ST_CLEAR: begin
        if (clr_cnt_r == '1) state_nxt = bpa_pkg::ST_IDLE;
      end
      bpa_pkg::ST_IDLE: begin
        if (accept) begin
          priority case (in_opcode)
            bpa_pkg::OP_ALLOC:
              state_nxt = alloc_go ? bpa_pkg::ST_SCAN_RD : bpa_pkg::ST_FIN;
            bpa_pkg::OP_FREE, bpa_pkg::OP_MARK_USED, bpa_pkg::OP_MARK_FREE:
              state_nxt = run_go ? bpa_pkg::ST_RUN_RD : bpa_pkg::ST_FIN;
            bpa_pkg::OP_TEST:
              state_nxt = bpa_pkg::ST_TEST_RD;
            default:
              state_nxt = bpa_pkg::ST_FIN;
          endcase
        end
      end
      bpa_pkg::ST_TEST_RD:  state_nxt = bpa_pkg::ST_TEST_CHK;
      bpa_pkg::ST_TEST_CHK: state_nxt = bpa_pkg::ST_FIN;
      bpa_pkg::ST_SCAN_RD:  state_nxt = bpa_pkg::ST_SCAN_BITS;
      bpa_pkg::ST_SCAN_BITS: begin
        if (found) state_nxt = bpa_pkg::ST_RUN_RD;
        else if (sub_r == 2'd3)
          state_nxt = (word_r == '1) ? bpa_pkg::ST_FIN : bpa_pkg::ST_SCAN_RD;
      end
      bpa_pkg::ST_RUN_RD: state_nxt = bpa_pkg::ST_RUN_WR;
      bpa_pkg::ST_RUN_WR: state_nxt = last_word ? bpa_pkg::ST_FIN : bpa_pkg::ST_RUN_RD;
      bpa_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = bpa_pkg::ST_IDLE;
      end
      default: state_nxt = bpa_pkg::ST_CLEAR;
    endcase
  end

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = word_r;
    mem_wdata = '0;
    unique case (state_r)
      bpa_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_r;
      end
      bpa_pkg::ST_TEST_RD, bpa_pkg::ST_SCAN_RD, bpa_pkg::ST_RUN_RD: mem_re = 1'b1;
      bpa_pkg::ST_RUN_WR: begin
        mem_we    = 1'b1;
        mem_wdata = set_r ? (rd_data_r | run_mask) : (rd_data_r & ~run_mask);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_addr];
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      total_r     <= bpa_pkg::TOTAL_RESET;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) total_r <= cfg_wr_data;
      if (state_r == bpa_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        bpa_pkg::ST_IDLE: begin
          if (accept) begin
            page_r    <= in_page_index;
            len_r     <= len_c;
            lo_r      <= in_page_index;
            hi_r      <= in_hi_clip;
            // allocation scans from the bottom of the map
            word_r    <= (in_opcode == bpa_pkg::OP_ALLOC) ? '0 : in_page_index[15:5];
            sub_r     <= '0;
            run_r     <= '0;
            start_r   <= '0;
            tested_r  <= 1'b0;
            // allocation and undefined opcodes start out failed
            success_r <= (in_opcode != bpa_pkg::OP_ALLOC) &&
                         (in_opcode <= bpa_pkg::OP_MARK_FREE);
            set_r     <= (in_opcode == bpa_pkg::OP_ALLOC) ||
                         (in_opcode == bpa_pkg::OP_MARK_USED);
            // count drops even for pages already free; clamp at zero
            if (in_opcode == bpa_pkg::OP_FREE && run_go)
              used_r <= (used_r >= {8'd0, len_c}) ? used_r - {8'd0, len_c} : '0;
          end
        end
        bpa_pkg::ST_TEST_CHK: begin
          tested_r <= (page_r == '0) ? 1'b1 : rd_data_r[page_r[4:0]];
        end
        bpa_pkg::ST_SCAN_BITS: begin
          run_r <= run_c;
          sub_r <= sub_r + 1'b1;
          if (found) begin
            // hand the run to the write-back path
            start_r   <= found_start;
            lo_r      <= found_start;
            hi_r      <= found_pg;
            word_r    <= found_start[15:5];
            success_r <= 1'b1;
            used_r    <= used_r + {8'd0, len_r};
          end else if (sub_r == 2'd3) begin
            word_r <= word_r + 1'b1;
          end
        end
        bpa_pkg::ST_RUN_WR: begin
          if (!last_word) word_r <= word_r + 1'b1;
        end
        bpa_pkg::ST_FIN: begin
          if (out_load) begin
            out_success    <= success_r;
            out_start_page <= start_r;
            out_page_used  <= tested_r;
            out_used_count <= used_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  `BPA_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, state_r != bpa_pkg::ST_IDLE, "idle after accept")
  `BPA_ASSERT_IMP(a_port_excl, clk, rst_n, mem_we, !mem_re, "RAM read and write together")
  `BPA_ASSERT_IMP(a_no_rdy_clear, clk, rst_n, state_r == bpa_pkg::ST_CLEAR, !in_ready, "ready while clearing")

endmodule

// ===== verif/bitmap_page_allocator_core_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the bitmap page allocator: watches both channels and the cfg port.
// Depends on bpa_pkg for the opcode names and field widths.
module bitmap_page_allocator_core_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [bpa_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [2:0]                 in_opcode,
  input  logic [bpa_pkg::PAGE_W-1:0] in_page_index,
  input  logic [bpa_pkg::LEN_W-1:0]  in_run_length,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_success,
  input  logic [bpa_pkg::PAGE_W-1:0] out_start_page,
  input  logic                       out_page_used,
  input  logic [bpa_pkg::CNT_W-1:0]  out_used_count,
  output int                         fail_count,
  output int                         pending,
  output int                         checked,
  output int                         allocs_granted
);

  typedef struct packed {
    logic                       success;
    logic [bpa_pkg::PAGE_W-1:0] start_page;
    logic                       page_used;
    logic [bpa_pkg::CNT_W-1:0]  used_count;
  } alloc_result_t;

  localparam int NUM_PAGES = bpa_pkg::WORD_BITS * bpa_pkg::NUM_WORDS;

  bit            page_map [NUM_PAGES];
  int            used_total;
  int            page_limit;
  alloc_result_t result_q [$];

  function automatic bit page_taken(int p);
    if (p == 0 || p >= NUM_PAGES) return 1'b1;
    return page_map[p];
  endfunction

  function automatic void paint_run(int first, int len, bit val);
    for (int k = 0; k < len; k++)
      if (first + k != 0 && first + k < NUM_PAGES) page_map[first + k] = val;
  endfunction

  function automatic alloc_result_t predict_op(logic [2:0] op, int page, int len);
    alloc_result_t r;
    int run;
    r = '0;
    r.success = 1'b1;
    if (len > int'(bpa_pkg::MAX_RUN)) len = int'(bpa_pkg::MAX_RUN);
    case (op)
      bpa_pkg::OP_ALLOC: begin
        r.success = 1'b0;
        run = 0;
        if (len != 0 && used_total + len <= page_limit) begin
          for (int p = 1; p < NUM_PAGES; p++) begin
            if (page_taken(p)) begin
              run = 0;
            end else begin
              run++;
              if (run == len) begin
                r.start_page = bpa_pkg::PAGE_W'(p + 1 - len);
                paint_run(p + 1 - len, len, 1'b1);
                used_total += len;
                r.success = 1'b1;
                break;
              end
            end
          end
        end
      end
      bpa_pkg::OP_FREE: begin
        if (page != 0 && len != 0) begin
          paint_run(page, len, 1'b0);
          used_total = (used_total >= len) ? used_total - len : 0;
        end
      end
      bpa_pkg::OP_TEST: r.page_used = page_taken(page);
      bpa_pkg::OP_MARK_USED, bpa_pkg::OP_MARK_FREE: begin
        if (page != 0) paint_run(page, len, op == bpa_pkg::OP_MARK_USED);
      end
      default: r.success = 1'b0;
    endcase
    r.used_count = bpa_pkg::CNT_W'(used_total);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch on result %0d: got %0d, want %0d",
             $realtime, what, checked, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
    allocs_granted = 0;
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      foreach (page_map[i]) page_map[i] = 1'b0;
      used_total = 0;
      page_limit = int'(bpa_pkg::TOTAL_RESET);
      result_q.delete();
    end else begin
      if (cfg_wr_en) page_limit = int'(cfg_wr_data);
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_success !== want.success)
            report_mismatch("success", out_success, want.success);
          if (out_start_page !== want.start_page)
            report_mismatch("start_page", out_start_page, want.start_page);
          if (out_page_used !== want.page_used)
            report_mismatch("page_used", out_page_used, want.page_used);
          if (out_used_count !== want.used_count)
            report_mismatch("used_count", out_used_count, want.used_count);
        end
        checked++;
      end
      if (in_valid && in_ready) begin
        want = predict_op(in_opcode, int'(in_page_index), int'(in_run_length));
        if (in_opcode == bpa_pkg::OP_ALLOC && want.success) allocs_granted++;
        result_q.push_back(want);
      end
    end
    pending <= result_q.size();
  end

endmodule

// ===== verif/bitmap_page_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, stimulus and verdict.
// Depends on bpa_pkg, bitmap_page_allocator_core and its checker module.
module bitmap_page_allocator_core_tb;

  // opcodes past the last defined one; the block must reject them
  localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd5;
  localparam int         HOLD_CYCLES      = 400;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [bpa_pkg::CNT_W-1:0]  cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [2:0]                 in_opcode = bpa_pkg::OP_TEST;
  logic [bpa_pkg::PAGE_W-1:0] in_page_index = '0;
  logic [bpa_pkg::LEN_W-1:0]  in_run_length = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_success;
  logic [bpa_pkg::PAGE_W-1:0] out_start_page;
  logic                       out_page_used;
  logic [bpa_pkg::CNT_W-1:0]  out_used_count;

  int fail_count, pending, checked, allocs_granted;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  always #4 clk = ~clk;

  bitmap_page_allocator_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_page_index  (in_page_index),
    .in_run_length  (in_run_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_success    (out_success),
    .out_start_page (out_start_page),
    .out_page_used  (out_page_used),
    .out_used_count (out_used_count)
  );

  bitmap_page_allocator_core_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_page_index  (in_page_index),
    .in_run_length  (in_run_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_success    (out_success),
    .out_start_page (out_start_page),
    .out_page_used  (out_page_used),
    .out_used_count (out_used_count),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked),
    .allocs_granted (allocs_granted)
  );

  // Receiver: random back-pressure, or a long counted hold when one is asked
  // for. The hold lets the output register fill so the block stalls in_ready.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_req  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offer one transfer; valid stays up across back-to-back items unless the
  // sender decides to idle first.
  task automatic send_op(logic [2:0] op, logic [bpa_pkg::PAGE_W-1:0] pg,
                         logic [bpa_pkg::LEN_W-1:0] len);
    int gap;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_page_index <= pg;
    in_run_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and hold until every expected result has been seen.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_limit(logic [bpa_pkg::CNT_W-1:0] lim);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed traffic over the low pages so that allocations,
  // frees and marks keep colliding; a little noise elsewhere.
  task automatic random_op;
    int sel, pr, lr;
    logic [2:0]                 op;
    logic [bpa_pkg::PAGE_W-1:0] pg;
    logic [bpa_pkg::LEN_W-1:0]  len;
    sel = $urandom_range(0, 99);
    if (sel < 35)      op = bpa_pkg::OP_ALLOC;
    else if (sel < 60) op = bpa_pkg::OP_FREE;
    else if (sel < 75) op = bpa_pkg::OP_TEST;
    else if (sel < 86) op = bpa_pkg::OP_MARK_USED;
    else if (sel < 97) op = bpa_pkg::OP_MARK_FREE;
    else               op = OP_UNKNOWN_FIRST + 3'($urandom_range(0, 2));
    pr = $urandom_range(0, 99);
    if (pr < 88)      pg = bpa_pkg::PAGE_W'($urandom_range(1, 4095));
    else if (pr < 94) pg = bpa_pkg::PAGE_W'($urandom_range(0, 65535));
    else              pg = bpa_pkg::PAGE_W'($urandom_range(65280, 65535));
    lr = $urandom_range(0, 99);
    if (lr < 80)      len = bpa_pkg::LEN_W'($urandom_range(1, 16));
    else if (lr < 92) len = bpa_pkg::LEN_W'($urandom_range(17, 256));
    else if (lr < 96) len = '0;
    else              len = bpa_pkg::LEN_W'($urandom_range(257, 511));
    send_op(op, pg, len);
  endtask

  initial begin
    #200_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("bitmap_page_allocator_core test failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first pages, clamping, page zero, zero length, the top of
    // the map, double free and the undefined opcodes.
    send_op(bpa_pkg::OP_TEST, 16'd0, 9'd1);
    send_op(bpa_pkg::OP_ALLOC, 16'd0, 9'd1);
    send_op(bpa_pkg::OP_ALLOC, 16'd0, 9'd256);
    send_op(bpa_pkg::OP_ALLOC, 16'd0, 9'd0);
    send_op(bpa_pkg::OP_ALLOC, 16'd0, 9'd511);
    send_op(bpa_pkg::OP_TEST, 16'd1, 9'd1);
    send_op(bpa_pkg::OP_FREE, 16'd0, 9'd8);
    send_op(bpa_pkg::OP_FREE, 16'd5, 9'd0);
    send_op(bpa_pkg::OP_FREE, 16'd1, 9'd1);
    send_op(bpa_pkg::OP_FREE, 16'd1, 9'd1);
    send_op(bpa_pkg::OP_MARK_USED, 16'd0, 9'd4);
    send_op(bpa_pkg::OP_MARK_USED, 16'd65500, 9'd300);
    send_op(bpa_pkg::OP_TEST, 16'd65535, 9'd1);
    send_op(bpa_pkg::OP_MARK_FREE, 16'd65535, 9'd1);
    send_op(bpa_pkg::OP_TEST, 16'd65535, 9'd1);
    send_op(bpa_pkg::OP_TEST, 16'd32768, 9'd1);
    send_op(bpa_pkg::OP_FREE, 16'd65400, 9'd256);
    for (int k = 0; k < 3; k++) send_op(OP_UNKNOWN_FIRST + 3'(k), 16'hFFFF, 9'h1FF);
    send_op(bpa_pkg::OP_ALLOC, 16'd0, 9'd3);

    // Tight limit, sender mostly busy and receiver mostly stalling.
    set_limit(17'd300);
    tx_idle_pct = 21;
    rx_idle_pct = 81;
    repeat (140) random_op();

    // Zero limit: every allocation has to fail.
    set_limit(17'd0);
    repeat (20) random_op();

    set_limit(17'd65535);
    tx_idle_pct = 81;
    rx_idle_pct = 21;
    repeat (70) random_op();
    // Hold the sender until the pipe is empty, then carry on.
    drain();
    repeat (70) random_op();

    set_limit(bpa_pkg::TOTAL_RESET);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (20) random_op();
    hold_req = 1'b1;
    repeat (110) random_op();

    drain();
    repeat (50) @(posedge clk);
    $display("%0d operations checked over five limit settings, %0d allocations granted",
             checked, allocs_granted);
    if (fail_count == 0) begin
      $display("bitmap_page_allocator_core test passed");
    end else begin
      $display("bitmap_page_allocator_core test failed");
    end
    $finish;
  end

endmodule
